FILE: design/u8d_pkg.sv
// shared types, constants and lead byte classifier for the utf-8 decoder
`timescale 1ns / 1ps

package u8d_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_terminator;
  } out_t;

  // work left for the back end from one input byte
  typedef struct packed {
    logic        has_unit;
    logic [15:0] unit;
    logic        has_term;
  } entry_t;

  typedef enum logic [1:0] {
    LEAD_ASCII,
    LEAD_MULTI,
    LEAD_BAD
  } lead_kind_t;

  typedef struct packed {
    lead_kind_t  kind;
    logic [2:0]  pending;
    logic [15:0] payload;
  } lead_t;

  function automatic lead_t classify_lead(input logic [7:0] b);
    lead_t r;
    r.kind    = LEAD_BAD;
    r.pending = 3'd0;
    r.payload = 16'd0;
    if (b[7] == 1'b0) begin
      r.kind    = LEAD_ASCII;
      r.payload = {8'd0, b};
    end else if ((b & 8'he0) == 8'hc0) begin
      r.kind    = LEAD_MULTI;
      r.pending = 3'd1;
      r.payload = {8'd0, b & 8'h1f};
    end else if ((b & 8'hf0) == 8'he0) begin
      r.kind    = LEAD_MULTI;
      r.pending = 3'd2;
      r.payload = {8'd0, b & 8'h0f};
    end else if ((b & 8'hf8) == 8'hf0) begin
      r.kind    = LEAD_MULTI;
      r.pending = 3'd3;
      r.payload = {8'd0, b & 8'h07};
    end else if ((b & 8'hfc) == 8'hf8) begin
      r.kind    = LEAD_MULTI;
      r.pending = 3'd4;
      r.payload = {8'd0, b & 8'h03};
    end else if ((b & 8'hfe) == 8'hfc) begin
      r.kind    = LEAD_MULTI;
      r.pending = 3'd5;
      r.payload = {8'd0, b & 8'h01};
    end
    return r;
  endfunction

endpackage

FILE: design/utf8_to_utf16_decoder.sv
// top level of the utf-8 to 16-bit code unit decoder
// each result of an accepted byte is written into the queue, then registered in the output stage, before it can leave
// throughput: one byte per cycle; a final byte that also completes a character gives two
// output transactions, the unit before the terminator, and in_ready drops only while the queue is full
// the front end classifies each lead byte and shift-ors continuations into the running state
// reset (rst, synchronous): clears the open sequence, the queue and the output stage
`timescale 1ns / 1ps

module utf8_to_utf16_decoder (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  u8d_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output u8d_pkg::out_t  out_data
);

  logic            q_full;
  logic            push;
  u8d_pkg::entry_t push_entry;
  logic            pop;
  logic            head_valid;
  u8d_pkg::entry_t head_entry;

  u8d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  u8d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  u8d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

FILE: design/u8d_front.sv
// front end: accepts bytes, tracks the open sequence and queues results
`timescale 1ns / 1ps

module u8d_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  u8d_pkg::in_t     in_data,
  input  logic             q_full,
  output logic             push,
  output u8d_pkg::entry_t  push_entry
);

  logic [2:0]     pending;
  logic [2:0]     pending_next;
  logic [15:0]    acc;
  logic [15:0]    acc_next;
  logic           accept;
  logic           is_cont;
  logic [15:0]    acc_shift;
  logic [2:0]     pend_dec;
  u8d_pkg::lead_t lead;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign is_cont   = (pending != 3'd0) && (in_data.byte_in[7:6] == 2'b10);
  assign acc_shift = {acc[9:0], in_data.byte_in[5:0]};
  assign pend_dec  = pending - 3'd1;
  assign lead      = u8d_pkg::classify_lead(in_data.byte_in);

  always_comb begin
    pending_next        = pending;
    acc_next            = acc;
    push_entry.has_unit = 1'b0;
    push_entry.unit     = 16'd0;
    push_entry.has_term = 1'b0;
    if (accept) begin
      if (is_cont) begin
        pending_next = pend_dec;
        if (pend_dec == 3'd0) begin
          push_entry.has_unit = 1'b1;
          push_entry.unit     = acc_shift;
          acc_next            = 16'd0;
        end else begin
          acc_next = acc_shift;
        end
      end else begin
        // bad continuation falls through here and restarts as a lead
        unique case (lead.kind)
          u8d_pkg::LEAD_ASCII: begin
            pending_next        = 3'd0;
            acc_next            = 16'd0;
            push_entry.has_unit = 1'b1;
            push_entry.unit     = lead.payload;
          end
          u8d_pkg::LEAD_MULTI: begin
            pending_next = lead.pending;
            acc_next     = lead.payload;
          end
          default: begin
            pending_next = 3'd0;
            acc_next     = 16'd0;
          end
        endcase
      end
      if (in_data.last_byte) begin
        pending_next        = 3'd0;
        acc_next            = 16'd0;
        push_entry.has_term = 1'b1;
      end
    end
  end

  assign push = accept && (push_entry.has_unit || push_entry.has_term);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
      acc     <= 16'd0;
    end else begin
      pending <= pending_next;
      acc     <= acc_next;
    end
  end

  // at most five continuations can be outstanding
  assert property (@(posedge clk) disable iff (rst) pending <= 3'd5)
    else $error("pending count out of range");

  // an idle decoder holds an empty accumulator
  assert property (@(posedge clk) disable iff (rst) (pending == 3'd0) |-> (acc == 16'd0))
    else $error("stale accumulator while idle");

endmodule

FILE: design/u8d_queue.sv
// small fifo between the front and back ends
`timescale 1ns / 1ps

module u8d_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  u8d_pkg::entry_t  push_entry,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output u8d_pkg::entry_t  head_entry
);

  u8d_pkg::entry_t               mem [u8d_pkg::QDEPTH];
  logic [u8d_pkg::QPTR_W-1:0]    wr_ptr;
  logic [u8d_pkg::QPTR_W-1:0]    rd_ptr;
  logic [u8d_pkg::QCNT_W-1:0]    count;
  logic                          do_push;
  logic                          do_pop;

  function automatic logic [u8d_pkg::QCNT_W-1:0] QCNT_INC(input logic b);
    return {{(u8d_pkg::QCNT_W-1){1'b0}}, b};
  endfunction

  assign full       = (count == u8d_pkg::QCNT_W'(u8d_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head_entry = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_INC(do_push) - QCNT_INC(do_pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
      count <= u8d_pkg::QCNT_W'(u8d_pkg::QDEPTH))
    else $error("queue count overflow");

  // the front end never offers an entry the queue cannot hold
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");

  // pointers stay consistent with the fill level
  assert property (@(posedge clk) disable iff (rst)
      (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with empty count");

endmodule

FILE: design/u8d_back.sv
// back end: turns queued entries into one output transaction per result
`timescale 1ns / 1ps

module u8d_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  u8d_pkg::entry_t  head_entry,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output u8d_pkg::out_t    out_data
);

  u8d_pkg::entry_t cur;
  u8d_pkg::entry_t cur_next;
  logic            out_fire;
  logic            take;

  assign out_valid = cur.has_unit || cur.has_term;
  assign out_fire  = out_valid && out_ready;
  // load a new entry when the current one is empty or about to be
  assign take      = !out_valid || (out_fire && (cur.has_unit ^ cur.has_term));
  assign pop       = take && head_valid;

  assign out_data.code_unit     = cur.has_unit ? cur.unit : 16'd0;
  assign out_data.is_terminator = !cur.has_unit;

  always_comb begin
    cur_next = cur;
    if (take) begin
      if (head_valid) begin
        cur_next = head_entry;
      end else begin
        cur_next.has_unit = 1'b0;
        cur_next.has_term = 1'b0;
      end
    end else if (out_fire) begin
      // unit goes first, terminator stays behind
      cur_next.has_unit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur.unit <= cur_next.unit;
    if (rst) begin
      cur.has_unit <= 1'b0;
      cur.has_term <= 1'b0;
    end else begin
      cur.has_unit <= cur_next.has_unit;
      cur.has_term <= cur_next.has_term;
    end
  end

endmodule

FILE: test/tb_utf8_to_utf16_decoder.sv
// self-checking testbench for the utf-8 to 16-bit code unit decoder
`timescale 1ns / 1ps

module tb_utf8_to_utf16_decoder;

  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_PER_PHASE = 340;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  u8d_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  u8d_pkg::out_t out_data;

  utf8_to_utf16_decoder uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  u8d_pkg::in_t byte_queue[$];
  u8d_pkg::out_t expected_units[$];

  // decoder state as predicted by the testbench
  logic [2:0] conts_left = 3'd0;
  logic [15:0] unit_acc = 16'd0;

  logic byte_taken = 1'b0;
  int bytes_queued = 0;
  int bytes_done = 0;
  int chars_seen = 0;
  int terms_seen = 0;
  int failures = 0;
  int stall_cycles = 0;
  int unsigned send_idle_pct = 30;
  int unsigned recv_idle_pct = 61;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic start_char(input logic [7:0] b);
    u8d_pkg::out_t unit;
    unit.is_terminator = 1'b0;
    casez (b)
      8'b0???????: begin
        unit.code_unit = {8'd0, b};
        expected_units.push_back(unit);
      end
      8'b110?????: begin
        unit_acc = {11'd0, b[4:0]};
        conts_left = 3'd1;
      end
      8'b1110????: begin
        unit_acc = {12'd0, b[3:0]};
        conts_left = 3'd2;
      end
      8'b11110???: begin
        unit_acc = {13'd0, b[2:0]};
        conts_left = 3'd3;
      end
      8'b111110??: begin
        unit_acc = {14'd0, b[1:0]};
        conts_left = 3'd4;
      end
      8'b1111110?: begin
        unit_acc = {15'd0, b[0]};
        conts_left = 3'd5;
      end
      default: begin
        // stray continuation, 0xfe or 0xff: dropped
      end
    endcase
  endtask

  task automatic decode_byte(input u8d_pkg::in_t item);
    u8d_pkg::out_t unit;
    if (conts_left != 3'd0) begin
      if (item.byte_in[7:6] == 2'b10) begin
        unit_acc = {unit_acc[9:0], item.byte_in[5:0]};
        conts_left = conts_left - 3'd1;
        if (conts_left == 3'd0) begin
          unit.code_unit = unit_acc;
          unit.is_terminator = 1'b0;
          expected_units.push_back(unit);
          unit_acc = 16'd0;
        end
      end else begin
        // broken sequence: drop it and look at this byte as a new lead
        conts_left = 3'd0;
        unit_acc = 16'd0;
        start_char(item.byte_in);
      end
    end else begin
      start_char(item.byte_in);
    end
    if (item.last_byte) begin
      conts_left = 3'd0;
      unit_acc = 16'd0;
      unit.code_unit = 16'd0;
      unit.is_terminator = 1'b1;
      expected_units.push_back(unit);
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic last);
    u8d_pkg::in_t item;
    item.byte_in = b;
    item.last_byte = last;
    byte_queue.push_back(item);
    bytes_queued++;
  endtask

  // mostly well-formed characters, some cut short, some raw noise
  task automatic queue_random_text(input int count);
    int pushed;
    int unsigned pick;
    int unsigned len_pick;
    int seq_len;
    int conts;
    logic [7:0] lead;
    pushed = 0;
    while (pushed < count) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        len_pick = $urandom_range(99);
        if (len_pick < 30) seq_len = 1;
        else if (len_pick < 55) seq_len = 2;
        else if (len_pick < 75) seq_len = 3;
        else if (len_pick < 87) seq_len = 4;
        else if (len_pick < 94) seq_len = 5;
        else seq_len = 6;
        case (seq_len)
          1: lead = {1'b0, 7'($urandom)};
          2: lead = {3'b110, 5'($urandom)};
          3: lead = {4'b1110, 4'($urandom)};
          4: lead = {5'b11110, 3'($urandom)};
          5: lead = {6'b111110, 2'($urandom)};
          default: lead = {7'b1111110, 1'($urandom)};
        endcase
        conts = seq_len - 1;
        if (pick >= 70 && seq_len > 1) conts = $urandom_range(seq_len - 2);
        queue_byte(lead, $urandom_range(15) == 0);
        pushed++;
        repeat (conts) begin
          queue_byte({2'b10, 6'($urandom)}, $urandom_range(15) == 0);
          pushed++;
        end
      end else begin
        queue_byte(8'($urandom), $urandom_range(15) == 0);
        pushed++;
      end
    end
  endtask

  task automatic drain;
    while (bytes_done < bytes_queued) @(negedge clk);
    while (expected_units.size() != 0) @(negedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    logic next_valid;
    u8d_pkg::in_t next_item;
    next_valid = in_valid;
    next_item = in_data;
    if (rst) begin
      next_valid = 1'b0;
    end else if (!in_valid || byte_taken) begin
      if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = byte_queue.pop_front();
        next_valid = 1'b1;
      end else begin
        next_valid = 1'b0;
      end
    end
    in_valid <= next_valid;
    in_data <= next_item;
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: predict on every byte transaction, check every result transaction
  always @(posedge clk) begin
    u8d_pkg::out_t want;
    byte_taken <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) begin
        bytes_done++;
        decode_byte(in_data);
      end
      if (out_valid && out_ready) begin
        if (expected_units.size() == 0) begin
          $error("unexpected result: code_unit %h, is_terminator %b",
                 out_data.code_unit, out_data.is_terminator);
          failures++;
        end else begin
          want = expected_units.pop_front();
          if (out_data.code_unit !== want.code_unit) begin
            $error("code_unit: expected %h, actual %h", want.code_unit, out_data.code_unit);
            failures++;
          end
          if (out_data.is_terminator !== want.is_terminator) begin
            $error("is_terminator: expected %b, actual %b",
                   want.is_terminator, out_data.is_terminator);
            failures++;
          end
          if (want.is_terminator) terms_seen++;
          else chars_seen++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: ascii zero, stray continuation, lengths 2 to 6
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hc2, 1'b0); queue_byte(8'ha9, 1'b0);
    queue_byte(8'he2, 1'b0); queue_byte(8'h82, 1'b0); queue_byte(8'hac, 1'b0);
    queue_byte(8'hf0, 1'b0); queue_byte(8'h9f, 1'b0); queue_byte(8'h98, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hfb, 1'b0);
    repeat (4) queue_byte(8'hbf, 1'b0);
    queue_byte(8'hfd, 1'b0);
    repeat (5) queue_byte(8'hbf, 1'b0);
    // broken sequences: cut by ascii, cut by a bad lead on the last byte
    queue_byte(8'hc3, 1'b0); queue_byte(8'h7f, 1'b0);
    queue_byte(8'he2, 1'b0); queue_byte(8'hff, 1'b1);
    // unfinished sequence dropped at end of string, then char plus terminator
    queue_byte(8'hf4, 1'b0); queue_byte(8'h8f, 1'b1);
    queue_byte(8'hfe, 1'b0);
    queue_byte(8'h41, 1'b1);
    drain();

    queue_random_text(RANDOM_PER_PHASE);
    drain();

    send_idle_pct = 61;
    recv_idle_pct = 30;
    queue_random_text(RANDOM_PER_PHASE);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_text(RANDOM_PER_PHASE);
    drain();

    // let any stray late result show up
    repeat (10) @(negedge clk);

    $display("sent %0d bytes under three send/receive idle mixes", bytes_done);
    $display("checked %0d code units and %0d terminators", chars_seen, terms_seen);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
